// ----- rtl/pchot_pkg.sv -----
`timescale 1ns / 1ps
// types and constants shared by the hot-spot profiler cells and top level
// no dependencies

package pchot_pkg;

    localparam int PC_W     = 16;
    localparam int OP_W     = 8;
    localparam int COUNT_W  = 32;
    localparam int STAMP_W  = 32;
    localparam int SLOT_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ANALYSIS_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_EN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 32'd256;

    // input word: one executed instruction
    typedef struct packed {
        logic [PC_W-1:0] pc;
        logic [OP_W-1:0] opcode;
    } t_in_word;

    // output word: one table update
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               hit;
        logic               evicted;
        logic               opcode_changed;
        logic [COUNT_W-1:0] count;
        logic               loop_detected;
    } t_out_word;

    // one table entry as held in a cell
    typedef struct packed {
        logic [PC_W-1:0]    pc;
        logic [OP_W-1:0]    opcode;
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] stamp;
        logic               marked;
    } t_entry;

    // search token passed from cell to cell
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic               changed;
        logic               marked;
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] best_stamp;
    } t_scan;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_SCAN,
        ST_CALC,
        ST_WRITE
    } t_state;

endpackage

// ----- rtl/pchot_cell.sv -----
`timescale 1ns / 1ps
// one table entry with its stage of the search chain: pc match and oldest stamp
// depends on pchot_pkg

module pchot_cell
    import pchot_pkg::*;
#(
    parameter int CELL_INDEX = 0,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_word         i_key,
    input  logic [CNT_W-1:0] i_used,
    input  t_scan            i_scan,
    input  logic [IDX_W-1:0] i_hit_idx,
    input  logic [IDX_W-1:0] i_best_idx,
    input  logic             i_we,
    input  t_entry           i_wr,
    output t_scan            o_scan,
    output logic [IDX_W-1:0] o_hit_idx,
    output logic [IDX_W-1:0] o_best_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    t_entry           r_entry;
    t_scan            r_scan;
    t_scan            n_scan;
    logic             r_valid;
    logic [IDX_W-1:0] r_hit_idx;
    logic [IDX_W-1:0] n_hit_idx;
    logic [IDX_W-1:0] r_best_idx;
    logic [IDX_W-1:0] n_best_idx;
    logic             w_filled;
    logic             w_match;

    // entry storage, written once per update
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_entry <= i_wr;
        end
    end

    assign w_filled = (CNT_W'(CELL_INDEX) < i_used);
    assign w_match  = w_filled && (r_entry.pc == i_key.pc);

    // first hit wins, strictly smaller stamp takes over the oldest
    always_comb begin
        n_scan     = i_scan;
        n_hit_idx  = i_hit_idx;
        n_best_idx = i_best_idx;
        if (!i_scan.hit && w_match) begin
            n_scan.hit     = 1'b1;
            n_scan.changed = (r_entry.opcode != i_key.opcode);
            n_scan.count   = r_entry.count;
            n_scan.marked  = r_entry.marked;
            n_hit_idx      = MY_IDX;
        end
        if ((CELL_INDEX == 0) || (r_entry.stamp < i_scan.best_stamp)) begin
            n_scan.best_stamp = r_entry.stamp;
            n_best_idx        = MY_IDX;
        end
    end

    // token valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_scan.valid;
        end
    end

    // token payload
    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_hit_idx  <= n_hit_idx;
        r_best_idx <= n_best_idx;
    end

    always_comb begin
        o_scan       = r_scan;
        o_scan.valid = r_valid;
    end

    assign o_hit_idx  = r_hit_idx;
    assign o_best_idx = r_best_idx;

endmodule

// ----- rtl/pc_hotspot_table_lru_unit.sv -----
`timescale 1ns / 1ps
// instruction hot-spot profiler: fully associative pc table with oldest-stamp replacement
// depends on pchot_pkg and pchot_cell
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | i_in_valid, o_in_ready, i_in_word         | in
//  out     | o_out_valid, i_out_ready, o_out_word      | out
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data         | in
//
// a word is taken in idle; after a launch state a search token walks the row of
// cells one cell a cycle, then a calc state works out the count and a write state
// writes the chosen cell and registers the result; the next word is taken only
// after the write, so no word is taken while another is in flight. words accepted
// with analysis off give no result. reset is synchronous and active low and
// clears only control state; no clearing pass. the write cycle waits while the
// output register holds an untaken result; a result waiting there does not stop
// the next word.

module pc_hotspot_table_lru_unit
    import pchot_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] USED_FULL = CNT_W'(TABLE_DEPTH);

    // configuration
    logic               r_analysis_en;
    logic               r_loop_en;
    logic [COUNT_W-1:0] r_threshold;

    // control
    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_used;
    logic [STAMP_W-1:0] r_stamp;
    logic               r_out_valid;

    // word in flight
    t_in_word           r_key;
    logic [IDX_W-1:0]   r_slot;
    logic               r_hit;
    logic               r_evicted;
    logic               r_changed;
    logic               r_marked;
    logic [COUNT_W-1:0] r_count;
    t_out_word          r_out_word;

    // search chain
    t_scan              w_scan     [TABLE_DEPTH];
    logic [IDX_W-1:0]   w_hit_idx  [TABLE_DEPTH];
    logic [IDX_W-1:0]   w_best_idx [TABLE_DEPTH];
    t_scan              w_launch;
    t_scan              w_last;
    t_entry             w_wr;

    logic w_accept;
    logic w_out_free;
    logic w_commit;
    logic w_scan_done;
    logic w_full;
    logic w_loop;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_last      = w_scan[TABLE_DEPTH-1];
    assign w_scan_done = (r_state == ST_SCAN) && w_last.valid;
    assign w_commit    = (r_state == ST_WRITE) && w_out_free;
    assign w_full      = (r_used == USED_FULL);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_analysis_en <= 1'b0;
            r_loop_en     <= 1'b0;
            r_threshold   <= THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ANALYSIS_EN: r_analysis_en <= i_cfg_data[0];
                CFG_LOOP_EN:     r_loop_en     <= i_cfg_data[0];
                CFG_THRESHOLD:   r_threshold   <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_accept && r_analysis_en) n_state = ST_LAUNCH;
            ST_LAUNCH: n_state = ST_SCAN;
            ST_SCAN:   if (w_last.valid) n_state = ST_CALC;
            ST_CALC:   n_state = ST_WRITE;
            ST_WRITE:  if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready       = (r_state == ST_IDLE);
        w_launch         = '0;
        w_launch.valid   = (r_state == ST_LAUNCH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // row of cells
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        pchot_cell #(
            .CELL_INDEX (k),
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_key      (r_key),
            .i_used     (r_used),
            .i_scan     ((k == 0) ? w_launch : w_scan[(k == 0) ? 0 : k-1]),
            .i_hit_idx  ((k == 0) ? '0 : w_hit_idx[(k == 0) ? 0 : k-1]),
            .i_best_idx ((k == 0) ? '0 : w_best_idx[(k == 0) ? 0 : k-1]),
            .i_we       (w_commit && (r_slot == IDX_W'(k))),
            .i_wr       (w_wr),
            .o_scan     (w_scan[k]),
            .o_hit_idx  (w_hit_idx[k]),
            .o_best_idx (w_best_idx[k])
        );
    end

    // capture the key on acceptance
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= i_in_word;
        end
    end

    // pick the slot when the token leaves the last cell
    always_ff @(posedge i_clk) begin
        if (w_scan_done) begin
            r_hit     <= w_last.hit;
            r_changed <= w_last.hit && w_last.changed;
            r_evicted <= !w_last.hit && w_full;
            if (w_last.hit) begin
                r_slot <= w_hit_idx[TABLE_DEPTH-1];
            end else if (w_full) begin
                r_slot <= w_best_idx[TABLE_DEPTH-1];
            end else begin
                r_slot <= r_used[IDX_W-1:0];
            end
            // new or reset entry starts from zero and unmarked
            if (w_last.hit && !w_last.changed) begin
                r_count  <= w_last.count;
                r_marked <= w_last.marked;
            end else begin
                r_count  <= '0;
                r_marked <= 1'b0;
            end
        end else if (r_state == ST_CALC) begin
            // saturating increment
            if (r_count != COUNT_MAX) begin
                r_count <= r_count + COUNT_W'(1);
            end
        end
    end

    // loop flag and write-back entry
    assign w_loop = r_loop_en && (r_count >= r_threshold) && !r_marked;

    always_comb begin
        w_wr.pc     = r_key.pc;
        w_wr.opcode = r_key.opcode;
        w_wr.count  = r_count;
        w_wr.stamp  = r_stamp;
        w_wr.marked = r_marked || w_loop;
    end

    // fill count and running stamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_stamp <= '0;
        end else if (w_commit) begin
            r_stamp <= r_stamp + STAMP_W'(1);
            if (!r_hit && !w_full) begin
                r_used <= r_used + CNT_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_word.slot           <= SLOT_W'(r_slot);
            r_out_word.hit            <= r_hit;
            r_out_word.evicted        <= r_evicted;
            r_out_word.opcode_changed <= r_changed;
            r_out_word.count          <= r_count;
            r_out_word.loop_detected  <= w_loop;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
